FILE: rtl/mandel_pkg.sv
// Shared types and constants for the escape-time pixel core.
package mandel_pkg;

    // Plane and image geometry.
    localparam int MAX_DIM         = 4096;
    localparam int COORD_FRAC_BITS = 28;
    localparam int COORD_W         = 32;
    localparam int IDX_W           = 12;
    localparam int DIM_W           = 13;
    localparam int LIMIT_W         = 16;

    // Shared multiplier: 33-bit signed operands cover both the plane span and the coordinates.
    localparam int MUL_W  = COORD_W + 1;
    localparam int PROD_W = 2 * MUL_W;
    localparam int SQ_W   = 2 * COORD_W;

    // Mapping divider: magnitude of span times index over (dimension - 1).
    localparam int DIVIDEND_W = MUL_W + IDX_W;
    localparam int DIVISOR_W  = DIM_W;
    localparam int DIV_CNT_W  = $clog2(DIVIDEND_W + 1);

    // Width that holds every pre-saturation sum without overflow.
    localparam int SAT_W = PROD_W;

    // Escape threshold of 4.0 with twice the fraction bits.
    localparam logic [SQ_W-1:0] ESC_THRESH =
        (2 * COORD_FRAC_BITS > 61) ? {SQ_W{1'b1}} : (SQ_W'(4) << (2 * COORD_FRAC_BITS));

    // Configuration port.
    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    typedef enum logic [2:0] {
        REG_REAL_MIN   = 3'd0,
        REG_REAL_MAX   = 3'd1,
        REG_IMAG_MIN   = 3'd2,
        REG_IMAG_MAX   = 3'd3,
        REG_WIDTH      = 3'd4,
        REG_HEIGHT     = 3'd5,
        REG_ITER_LIMIT = 3'd6
    } cfg_reg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MAPX_MUL,
        ST_MAPX_DIVST,
        ST_MAPX_DIVW,
        ST_MAPY_MUL,
        ST_MAPY_DIVST,
        ST_MAPY_DIVW,
        ST_IT_XY,
        ST_IT_UPD,
        ST_IT_XX,
        ST_IT_YY,
        ST_IT_CHK,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic                  start;
        logic [DIVIDEND_W-1:0] dividend;
        logic [DIVISOR_W-1:0]  divisor;
    } div_req_t;

    typedef struct packed {
        logic                  done;
        logic [DIVIDEND_W-1:0] quotient;
    } div_rsp_t;

endpackage

FILE: rtl/mandel_div.sv
// Restoring unsigned divider that retires one quotient bit per cycle.
module mandel_div (
    input  logic                 clk,
    input  logic                 rst_n,
    input  mandel_pkg::div_req_t req,
    output mandel_pkg::div_rsp_t rsp
);
    import mandel_pkg::*;

    logic                  busy_reg;
    logic                  done_reg;
    logic [DIV_CNT_W-1:0]  cnt_reg;
    logic [DIVISOR_W-1:0]  rem_reg;
    logic [DIVISOR_W-1:0]  divisor_reg;
    logic [DIVIDEND_W-1:0] quo_reg;

    logic [DIVISOR_W:0]    rem_shift;
    logic                  fits;
    logic [DIVISOR_W:0]    trial;

    // The remainder stays below the divisor, so the shifted value fits one extra bit.
    assign rem_shift = {rem_reg, quo_reg[DIVIDEND_W-1]};
    assign fits      = rem_shift >= {1'b0, divisor_reg};
    assign trial     = rem_shift - {1'b0, divisor_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == DIV_CNT_W'(1));
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= DIV_CNT_W'(DIVIDEND_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - DIV_CNT_W'(1);
                if (cnt_reg == DIV_CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg     <= '0;
            quo_reg     <= req.dividend;
            divisor_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? trial[DIVISOR_W-1:0] : rem_shift[DIVISOR_W-1:0];
            quo_reg <= {quo_reg[DIVIDEND_W-2:0], fits};
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

FILE: rtl/mandelbrot_escape_time_pixel_core.sv
// Escape-time pixel core: maps a pixel onto the plane and counts Mandelbrot iterations.
//
// Input channel: pixel_col and pixel_row move as one beat when pixel_valid is high and
// pixel_stall is low. The core takes one pixel at a time and holds pixel_stall high
// from the beat until the pixel's count has been loaded into the output register.
// Output channel: iteration_count moves when count_valid is high and count_stall is low.
// A finished count waits in the output register while the receiver stalls, and a new
// pixel may already be taken meanwhile; a second count waits until the first is taken.
// Each coordinate is mapped by one multiply step and then by the bit-serial divider
// (one quotient bit per cycle over 45 bits). Each iteration of the loop then uses the
// one shared 33x33 multiplier to form x*y, x*x and y*y in turn, and a final step loads
// the result register. The iteration count N runs from 1 to iteration_limit.
// Configuration sits on an APB-style port, one 32-bit register per word address; write
// only while no pixel is in flight. Reset clears the control state and loads the
// default plane (-2.0 to 1.0 by -1.0 to 1.0), a 1024 by 1024 image and a limit of 256.
module mandelbrot_escape_time_pixel_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [mandel_pkg::ADDR_W-1:0]       paddr,
    input  logic [mandel_pkg::DATA_W-1:0]       pwdata,
    output logic [mandel_pkg::DATA_W-1:0]       prdata,
    output logic                                pready,
    input  logic                                pixel_valid,
    output logic                                pixel_stall,
    input  logic [mandel_pkg::IDX_W-1:0]        pixel_col,
    input  logic [mandel_pkg::IDX_W-1:0]        pixel_row,
    output logic                                count_valid,
    input  logic                                count_stall,
    output logic [mandel_pkg::LIMIT_W-1:0]      iteration_count
);
    import mandel_pkg::*;

    localparam logic signed [SAT_W-1:0] SAT_HI = SAT_W'(2147483647);
    localparam logic signed [SAT_W-1:0] SAT_LO = -SAT_HI - SAT_W'(1);

    function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [SAT_W-1:0] v);
        logic signed [COORD_W-1:0] r;
        if (v > SAT_HI)
        begin
            r = COORD_W'(SAT_HI);
        end
        else if (v < SAT_LO)
        begin
            r = COORD_W'(SAT_LO);
        end
        else
        begin
            r = v[COORD_W-1:0];
        end
        return r;
    endfunction

    function automatic logic [DIVISOR_W-1:0] span_divisor(input logic [DIM_W-1:0] d);
        logic [DIM_W-1:0] c;
        if (d < DIM_W'(2))
        begin
            c = DIM_W'(2);
        end
        else if (32'(d) > MAX_DIM)
        begin
            c = DIM_W'(MAX_DIM);
        end
        else
        begin
            c = d;
        end
        return DIVISOR_W'(c - DIM_W'(1));
    endfunction

    // Configuration registers.
    logic signed [COORD_W-1:0] real_min_reg, real_max_reg, imag_min_reg, imag_max_reg;
    logic [DIM_W-1:0]          width_reg, height_reg;
    logic [LIMIT_W-1:0]        limit_reg;

    // Sequencer and datapath registers.
    state_t                    state_reg, state_next;
    logic [IDX_W-1:0]          col_reg, row_reg;
    logic signed [PROD_W-1:0]  prod_reg;
    logic                      neg_reg;
    logic signed [COORD_W-1:0] x0_reg, y0_reg, x_reg, y_reg;
    logic [SQ_W-1:0]           xs_reg, ys_reg;
    logic [LIMIT_W-1:0]        count_reg;
    logic                      count_valid_reg;
    logic [LIMIT_W-1:0]        iteration_count_reg;

    // Combinational signals.
    cfg_reg_t                  cfg_idx;
    logic                      cfg_wr;
    logic signed [MUL_W-1:0]   span_x, span_y, mul_a, mul_b;
    logic signed [PROD_W-1:0]  prod_neg;
    div_req_t                  div_req;
    div_rsp_t                  div_rsp;
    logic signed [SAT_W-1:0]   map_off, map_lo, map_sum;
    logic signed [SQ_W-1:0]    xy_sh, diff, diff_sh;
    logic signed [SAT_W-1:0]   y_sum, x_sum;
    logic [SQ_W:0]             mag_sum;
    logic [LIMIT_W-1:0]        limit_eff;
    logic                      keep_going;
    logic                      out_free;

    // ---------------- Configuration port ----------------
    assign pready  = 1'b1;
    assign cfg_idx = cfg_reg_t'(paddr[ADDR_W-1:2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            real_min_reg <= -COORD_W'(536870912);
            real_max_reg <= COORD_W'(268435456);
            imag_min_reg <= -COORD_W'(268435456);
            imag_max_reg <= COORD_W'(268435456);
            width_reg    <= DIM_W'(1024);
            height_reg   <= DIM_W'(1024);
            limit_reg    <= LIMIT_W'(256);
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                REG_REAL_MIN:   real_min_reg <= pwdata;
                REG_REAL_MAX:   real_max_reg <= pwdata;
                REG_IMAG_MIN:   imag_min_reg <= pwdata;
                REG_IMAG_MAX:   imag_max_reg <= pwdata;
                REG_WIDTH:      width_reg    <= pwdata[DIM_W-1:0];
                REG_HEIGHT:     height_reg   <= pwdata[DIM_W-1:0];
                REG_ITER_LIMIT: limit_reg    <= pwdata[LIMIT_W-1:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            REG_REAL_MIN:   prdata = real_min_reg;
            REG_REAL_MAX:   prdata = real_max_reg;
            REG_IMAG_MIN:   prdata = imag_min_reg;
            REG_IMAG_MAX:   prdata = imag_max_reg;
            REG_WIDTH:      prdata = DATA_W'(width_reg);
            REG_HEIGHT:     prdata = DATA_W'(height_reg);
            REG_ITER_LIMIT: prdata = DATA_W'(limit_reg);
            default:        prdata = '0;
        endcase
    end

    // ---------------- Sequencer: next state ----------------
    assign out_free = !count_valid_reg || !count_stall;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:       if (pixel_valid) state_next = ST_MAPX_MUL;
            ST_MAPX_MUL:   state_next = ST_MAPX_DIVST;
            ST_MAPX_DIVST: state_next = ST_MAPX_DIVW;
            ST_MAPX_DIVW:  if (div_rsp.done) state_next = ST_MAPY_MUL;
            ST_MAPY_MUL:   state_next = ST_MAPY_DIVST;
            ST_MAPY_DIVST: state_next = ST_MAPY_DIVW;
            ST_MAPY_DIVW:  if (div_rsp.done) state_next = ST_IT_XY;
            ST_IT_XY:      state_next = ST_IT_UPD;
            ST_IT_UPD:     state_next = ST_IT_XX;
            ST_IT_XX:      state_next = ST_IT_YY;
            ST_IT_YY:      state_next = ST_IT_CHK;
            ST_IT_CHK:     state_next = keep_going ? ST_IT_UPD : ST_DONE;
            ST_DONE:       if (out_free) state_next = ST_IDLE;
            default:       state_next = ST_IDLE;
        endcase
    end

    // ---------------- Sequencer: outputs ----------------
    assign span_x = MUL_W'(real_max_reg) - MUL_W'(real_min_reg);
    assign span_y = MUL_W'(imag_max_reg) - MUL_W'(imag_min_reg);

    always_comb
    begin
        pixel_stall = 1'b1;
        mul_a       = '0;
        mul_b       = '0;
        unique case (state_reg) inside
            ST_IDLE:
            begin
                pixel_stall = 1'b0;
            end
            ST_MAPX_MUL:
            begin
                mul_a = span_x;
                mul_b = $signed({{(MUL_W-IDX_W){1'b0}}, col_reg});
            end
            ST_MAPY_MUL:
            begin
                mul_a = span_y;
                mul_b = $signed({{(MUL_W-IDX_W){1'b0}}, row_reg});
            end
            ST_IT_XY, ST_IT_CHK:
            begin
                mul_a = MUL_W'(x_reg);
                mul_b = MUL_W'(y_reg);
            end
            ST_IT_XX:
            begin
                mul_a = MUL_W'(x_reg);
                mul_b = MUL_W'(x_reg);
            end
            ST_IT_YY:
            begin
                mul_a = MUL_W'(y_reg);
                mul_b = MUL_W'(y_reg);
            end
            default: ;
        endcase
    end

    // ---------------- Mapping divider ----------------
    assign prod_neg = -prod_reg;

    always_comb
    begin
        div_req.start    = (state_reg == ST_MAPX_DIVST) || (state_reg == ST_MAPY_DIVST);
        div_req.dividend = prod_reg[PROD_W-1] ? prod_neg[DIVIDEND_W-1:0]
                                              : prod_reg[DIVIDEND_W-1:0];
        div_req.divisor  = (state_reg == ST_MAPX_DIVST) ? span_divisor(width_reg)
                                                        : span_divisor(height_reg);
    end

    mandel_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // The quotient is a magnitude; C-style truncation restores the sign afterwards.
    assign map_off = neg_reg ? -$signed(SAT_W'(div_rsp.quotient))
                             : $signed(SAT_W'(div_rsp.quotient));
    assign map_lo  = (state_reg == ST_MAPX_DIVW) ? SAT_W'(real_min_reg) : SAT_W'(imag_min_reg);
    assign map_sum = map_off + map_lo;

    // ---------------- Iteration datapath ----------------
    assign xy_sh   = $signed(prod_reg[SQ_W-1:0]) >>> (COORD_FRAC_BITS - 1);
    assign diff    = $signed(xs_reg) - $signed(ys_reg);
    assign diff_sh = diff >>> COORD_FRAC_BITS;
    assign y_sum   = SAT_W'(xy_sh) + SAT_W'(y0_reg);
    assign x_sum   = SAT_W'(diff_sh) + SAT_W'(x0_reg);

    assign mag_sum    = {1'b0, xs_reg} + {1'b0, prod_reg[SQ_W-1:0]};
    assign limit_eff  = (limit_reg == '0) ? LIMIT_W'(1) : limit_reg;
    assign keep_going = (mag_sum <= {1'b0, ESC_THRESH}) && (count_reg < limit_eff);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            count_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if ((state_reg == ST_DONE) && out_free)
            begin
                count_valid_reg <= 1'b1;
            end
            else if (!count_stall)
            begin
                count_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
        if (pixel_valid && !pixel_stall)
        begin
            col_reg <= pixel_col;
            row_reg <= pixel_row;
        end
        if (div_req.start)
        begin
            neg_reg <= prod_reg[PROD_W-1];
        end
        if ((state_reg == ST_MAPX_DIVW) && div_rsp.done)
        begin
            x0_reg <= sat_coord(map_sum);
        end
        if ((state_reg == ST_MAPY_DIVW) && div_rsp.done)
        begin
            y0_reg    <= sat_coord(map_sum);
            x_reg     <= '0;
            y_reg     <= '0;
            xs_reg    <= '0;
            ys_reg    <= '0;
            count_reg <= '0;
        end
        if (state_reg == ST_IT_UPD)
        begin
            y_reg     <= sat_coord(y_sum);
            x_reg     <= sat_coord(x_sum);
            count_reg <= count_reg + LIMIT_W'(1);
        end
        if (state_reg == ST_IT_YY)
        begin
            xs_reg <= prod_reg[SQ_W-1:0];
        end
        if (state_reg == ST_IT_CHK)
        begin
            ys_reg <= prod_reg[SQ_W-1:0];
        end
        if ((state_reg == ST_DONE) && out_free)
        begin
            iteration_count_reg <= count_reg;
        end
    end

    assign count_valid     = count_valid_reg;
    assign iteration_count = iteration_count_reg;

`ifndef SYNTH
    // A beat on the input channel always starts the column mapping.
    a_accept_starts_map: assert property (@(posedge clk) disable iff (!rst_n)
        (pixel_valid && !pixel_stall) |=> (state_reg == ST_MAPX_MUL))
        else $error("accepted pixel did not start the mapping");

    // The divider only finishes while the sequencer waits for it.
    a_div_done_expected: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> ((state_reg == ST_MAPX_DIVW) || (state_reg == ST_MAPY_DIVW)))
        else $error("divider finished outside a wait state");

    // At each escape check the count lies between one and the limit.
    a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IT_CHK) |-> ((count_reg != '0) && (count_reg <= limit_eff)))
        else $error("iteration count out of range");

    // A delivered count is never zero.
    a_result_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        count_valid |-> (iteration_count != '0))
        else $error("zero iteration count delivered");
`endif

endmodule
